[design/htd_pkg.sv]
// Package for the Huffman tree decoder: command, status and state codes.
`timescale 1ns / 1ps

package htd_pkg;

  // Byte that announces a leaf during tree loading.
  localparam logic [7:0] LeafMark = 8'h4C;
  // Symbols at or above this value are rejected as leaves.
  localparam int unsigned AlphabetSize = 256;
  localparam int unsigned SymW = 8;
  localparam int unsigned CntW = 32;

  typedef enum logic [1:0] {
    CMD_TREE    = 2'd0,
    CMD_DATA    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_SYMBOL      = 2'd0,
    ST_NO_TREE     = 2'd1,
    ST_SINGLE_LEAF = 2'd2,
    ST_OVERFLOW    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_FETCH,
    S_WALK,
    S_FLUSH
  } state_e;

endpackage

[design/htd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module htd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds its value until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/huffman_tree_decoder_core.sv]
// Top level of the Huffman tree decoder: tree loader, bit-serial tree walk, result queue.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------
//   in      | input     | in_valid_i / in_ready_o   | cmd_i, data_byte_i
//   out     | output    | out_valid_o / out_ready_i | symbol_o, status_o, last_o
//   cfg     | input     | cfg_we_i                  | cfg_data_i (symbol_total)
//
// A tree byte passes the pop state when a leaf closes the top open node and the next one is
// read back from the stack memory, and the flush state when it reports an error. The walk
// of a data byte shifts one bit per cycle unless stalled, each bit waiting on one registered
// read of the node store. An ignored data byte stays idle; a flagged one passes the flush
// state. Reset clears all control state at once; the node and stack memories need no
// clearing pass. A full output register stalls the walk when a symbol is found while the
// one before it still waits in the holding register, and holds the final flush until taken.
`timescale 1ns / 1ps

module huffman_tree_decoder_core
  import htd_pkg::*;
#(
  parameter int unsigned NODE_DEPTH  = 512,
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      cmd_i,
  input  logic [7:0]      data_byte_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [SymW-1:0] symbol_o,
  output logic [1:0]      status_o,
  output logic            last_o,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_data_i
);

  localparam int unsigned IW  = $clog2(NODE_DEPTH);
  localparam int unsigned NCW = $clog2(NODE_DEPTH + 1);
  localparam int unsigned SW  = $clog2(STACK_DEPTH);
  localparam int unsigned LW  = $clog2(STACK_DEPTH + 1);

  // Control state
  state_e           state_q, state_d;
  logic [LW-1:0]    level_q, level_d;
  logic [NCW-1:0]   nodes_q, nodes_d;
  logic             expect_q, expect_d;
  logic             complete_q, complete_d;
  logic [IW-1:0]    walk_q, walk_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  total_q;
  logic             pend_valid_q, pend_valid_d;
  logic             out_valid_q, out_valid_d;
  logic             root_leaf_q, root_leaf_d;

  // Payload registers
  logic [IW:0]      top_q, top_d;        // {left child present, node index}
  logic [IW-1:0]    root_left_q, root_left_d;
  logic [IW-1:0]    root_right_q, root_right_d;
  logic [7:0]       shreg_q, shreg_d;
  logic [2:0]       bit_cnt_q, bit_cnt_d;
  logic [IW-1:0]    nxt_q, nxt_d;
  logic [SymW-1:0]  pend_sym_q, pend_sym_d;
  status_e          pend_st_q, pend_st_d;
  logic [SymW-1:0]  out_sym_q, out_sym_d;
  status_e          out_st_q, out_st_d;
  logic             out_last_q, out_last_d;

  // Memory ports
  logic             info_we, left_we, right_we, node_re;
  logic [IW-1:0]    info_waddr, left_waddr, right_waddr, node_raddr;
  logic [SymW:0]    info_wdata, info_rd;
  logic [IW-1:0]    left_wdata, right_wdata, left_rd, right_rd;
  logic             stk_we, stk_re;
  logic [SW-1:0]    stk_waddr, stk_raddr;
  logic [IW:0]      stk_wdata, stk_rd;

  // Shared conditions
  cmd_e             cmd;
  logic             in_fire, out_free;
  logic             nodes_full, stack_full, has_parent, left_done;
  logic             sym_bad, leaf_bad, int_bad;
  logic             is_tree, tree_err, leaf_pop, is_data, data_err, data_go;
  logic             w_leaf, w_reached, w_stall, w_done;
  logic [CntW-1:0]  cnt_inc;
  logic [LW-1:0]    lvl_m1, lvl_m2;
  logic [IW-1:0]    new_idx, parent;

  assign cmd        = cmd_e'(cmd_i);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign nodes_full = nodes_q >= NCW'(NODE_DEPTH);
  assign stack_full = level_q >= LW'(STACK_DEPTH);
  assign has_parent = level_q != '0;
  assign left_done  = top_q[IW];
  assign parent     = top_q[IW-1:0];
  assign new_idx    = nodes_q[IW-1:0];
  assign lvl_m1     = level_q - LW'(1);
  assign lvl_m2     = level_q - LW'(2);

  assign sym_bad  = {1'b0, data_byte_i} >= 9'(AlphabetSize);
  assign leaf_bad = expect_q && (sym_bad || nodes_full);
  assign int_bad  = !expect_q && (nodes_full || (data_byte_i != LeafMark && stack_full));
  assign is_tree  = in_fire && cmd == CMD_TREE && !complete_q;
  assign tree_err = is_tree && (leaf_bad || int_bad);
  assign leaf_pop = is_tree && expect_q && !leaf_bad && has_parent && left_done
                    && level_q != LW'(1);

  assign is_data  = in_fire && cmd == CMD_DATA;
  assign data_err = is_data && (!complete_q || (cnt_q < total_q && root_leaf_q));
  assign data_go  = is_data && complete_q && cnt_q < total_q && !root_leaf_q;

  assign cnt_inc   = cnt_q + CntW'(1);
  assign w_leaf    = info_rd[SymW];
  assign w_reached = cnt_inc >= total_q;
  assign w_stall   = w_leaf && pend_valid_q && !out_free;
  assign w_done    = w_leaf ? (w_reached || bit_cnt_q == '0) : (bit_cnt_q == '0);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        priority if (tree_err || data_err) begin
          state_d = S_FLUSH;
        end else if (leaf_pop) begin
          state_d = S_POP;
        end else if (data_go) begin
          state_d = S_FETCH;
        end
      end
      S_POP:   state_d = S_IDLE;
      S_FETCH: state_d = S_WALK;
      S_WALK: begin
        if (!w_stall && w_done) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!pend_valid_q || out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    level_d      = level_q;
    nodes_d      = nodes_q;
    expect_d     = expect_q;
    complete_d   = complete_q;
    walk_d       = walk_q;
    cnt_d        = cnt_q;
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    pend_st_d    = pend_st_q;
    root_leaf_d  = root_leaf_q;
    top_d        = top_q;
    root_left_d  = root_left_q;
    root_right_d = root_right_q;
    shreg_d      = shreg_q;
    bit_cnt_d    = bit_cnt_q;
    nxt_d        = nxt_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_sym_d    = out_sym_q;
    out_st_d     = out_st_q;
    out_last_d   = out_last_q;

    info_we     = 1'b0;
    info_waddr  = new_idx;
    info_wdata  = {1'b0, data_byte_i};
    left_we     = 1'b0;
    left_waddr  = parent;
    left_wdata  = new_idx;
    right_we    = 1'b0;
    right_waddr = parent;
    right_wdata = new_idx;
    node_re     = 1'b0;
    node_raddr  = walk_q;
    stk_we      = 1'b0;
    stk_waddr   = lvl_m1[SW-1:0];
    stk_wdata   = {1'b1, parent};
    stk_re      = 1'b0;
    stk_raddr   = lvl_m2[SW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (cmd)
            CMD_RESTART: begin
              level_d    = '0;
              nodes_d    = '0;
              expect_d   = 1'b0;
              complete_d = 1'b0;
              walk_d     = '0;
              cnt_d      = '0;
            end
            CMD_TREE: begin
              if (tree_err) begin
                pend_valid_d = 1'b1;
                pend_sym_d   = '0;
                pend_st_d    = ST_OVERFLOW;
              end else if (is_tree && expect_q) begin
                // Leaf symbol: store it and hang it under the open node on top.
                info_we    = 1'b1;
                info_wdata = {1'b1, data_byte_i};
                nodes_d    = nodes_q + NCW'(1);
                expect_d   = 1'b0;
                if (new_idx == '0) begin
                  root_leaf_d = 1'b1;
                end
                if (!has_parent) begin
                  complete_d = 1'b1;
                end else if (!left_done) begin
                  left_we = 1'b1;
                  top_d   = {1'b1, parent};
                  if (parent == '0) begin
                    root_left_d = new_idx;
                  end
                end else begin
                  right_we = 1'b1;
                  level_d  = lvl_m1;
                  if (parent == '0) begin
                    root_right_d = new_idx;
                  end
                  if (level_q == LW'(1)) begin
                    complete_d = 1'b1;
                  end else begin
                    stk_re = 1'b1;
                  end
                end
              end else if (is_tree && data_byte_i == LeafMark) begin
                expect_d = 1'b1;
              end else if (is_tree) begin
                // Internal node: a right child replaces the closed parent on top of the
                // stack; a left child pushes the parent down into the memory.
                info_we    = 1'b1;
                info_wdata = '0;
                nodes_d    = nodes_q + NCW'(1);
                top_d      = {1'b0, new_idx};
                if (new_idx == '0) begin
                  root_leaf_d = 1'b0;
                end
                if (has_parent && left_done) begin
                  right_we = 1'b1;
                  if (parent == '0) begin
                    root_right_d = new_idx;
                  end
                end else begin
                  level_d = level_q + LW'(1);
                  if (has_parent) begin
                    left_we = 1'b1;
                    stk_we  = 1'b1;
                    if (parent == '0) begin
                      root_left_d = new_idx;
                    end
                  end
                end
              end
            end
            CMD_DATA: begin
              if (data_err) begin
                pend_valid_d = 1'b1;
                pend_sym_d   = '0;
                pend_st_d    = complete_q ? ST_SINGLE_LEAF : ST_NO_TREE;
              end else if (data_go) begin
                node_re    = 1'b1;
                node_raddr = walk_q;
                shreg_d    = data_byte_i;
                bit_cnt_d  = 3'd7;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        top_d = stk_rd;
      end
      S_FETCH: begin
        node_re    = 1'b1;
        node_raddr = shreg_q[7] ? right_rd : left_rd;
        nxt_d      = node_raddr;
      end
      S_WALK: begin
        if (w_leaf) begin
          if (!w_stall) begin
            // The previous symbol is known not to be the last of this byte.
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_sym_d   = pend_sym_q;
              out_st_d    = pend_st_q;
              out_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_sym_d   = info_rd[SymW-1:0];
            pend_st_d    = ST_SYMBOL;
            cnt_d        = cnt_inc;
            walk_d       = '0;
            if (!w_done) begin
              node_re    = 1'b1;
              node_raddr = shreg_q[6] ? root_right_q : root_left_q;
              nxt_d      = node_raddr;
              shreg_d    = {shreg_q[6:0], 1'b0};
              bit_cnt_d  = bit_cnt_q - 3'd1;
            end
          end
        end else begin
          walk_d = nxt_q;
          if (!w_done) begin
            node_re    = 1'b1;
            node_raddr = shreg_q[6] ? right_rd : left_rd;
            nxt_d      = node_raddr;
            shreg_d    = {shreg_q[6:0], 1'b0};
            bit_cnt_d  = bit_cnt_q - 3'd1;
          end
        end
      end
      S_FLUSH: begin
        if (pend_valid_q && out_free) begin
          out_valid_d  = 1'b1;
          out_sym_d    = pend_sym_q;
          out_st_d     = pend_st_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      level_q      <= '0;
      nodes_q      <= '0;
      expect_q     <= 1'b0;
      complete_q   <= 1'b0;
      walk_q       <= '0;
      cnt_q        <= '0;
      total_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      root_leaf_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      level_q      <= level_d;
      nodes_q      <= nodes_d;
      expect_q     <= expect_d;
      complete_q   <= complete_d;
      walk_q       <= walk_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      root_leaf_q  <= root_leaf_d;
      if (cfg_we_i) begin
        total_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q        <= top_d;
    root_left_q  <= root_left_d;
    root_right_q <= root_right_d;
    shreg_q      <= shreg_d;
    bit_cnt_q    <= bit_cnt_d;
    nxt_q        <= nxt_d;
    pend_sym_q   <= pend_sym_d;
    pend_st_q    <= pend_st_d;
    out_sym_q    <= out_sym_d;
    out_st_q     <= out_st_d;
    out_last_q   <= out_last_d;
  end

  // Node store split by field so that each child link is written without a read first.
  htd_ram #(.WIDTH(SymW + 1), .DEPTH(NODE_DEPTH)) u_info_ram (
    .clk_i   (clk_i),
    .we_i    (info_we),
    .waddr_i (info_waddr),
    .wdata_i (info_wdata),
    .re_i    (node_re),
    .raddr_i (node_raddr),
    .rdata_o (info_rd)
  );

  htd_ram #(.WIDTH(IW), .DEPTH(NODE_DEPTH)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (left_we),
    .waddr_i (left_waddr),
    .wdata_i (left_wdata),
    .re_i    (node_re),
    .raddr_i (node_raddr),
    .rdata_o (left_rd)
  );

  htd_ram #(.WIDTH(IW), .DEPTH(NODE_DEPTH)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (right_we),
    .waddr_i (right_waddr),
    .wdata_i (right_wdata),
    .re_i    (node_re),
    .raddr_i (node_raddr),
    .rdata_o (right_rd)
  );

  // Holds the open nodes below the top entry, which lives in top_q.
  htd_ram #(.WIDTH(IW + 1), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rd)
  );

  assign out_valid_o = out_valid_q;
  assign symbol_o    = out_sym_q;
  assign status_o    = out_st_q;
  assign last_o      = out_last_q;

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LW'(STACK_DEPTH))
    else $error("open-node stack level beyond its depth");

  a_nodes_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nodes_q <= NCW'(NODE_DEPTH))
    else $error("node count beyond the node store depth");

  a_complete_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    complete_q |-> (level_q == '0 && !expect_q))
    else $error("tree marked complete with open nodes");

  a_walk_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (cnt_q < total_q))
    else $error("walk running after the symbol count was reached");

  a_flag_no_symbol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_SYMBOL) |-> (symbol_o == '0 && last_o))
    else $error("error result carries a symbol or is not last");
`endif

endmodule
